[src/mmc_pkg.sv]
// Package for the multicycle MIPS-style core: payload structs, opcodes,
// function codes, control word table and memory geometry. No dependencies.
`default_nettype none
package mmc_pkg;

    localparam int RAM_BYTES  = 128;
    localparam int MEM_AW     = $clog2(RAM_BYTES);
    localparam int BANK_DEPTH = RAM_BYTES / 4;
    localparam int BANK_AW    = MEM_AW - 2;

    typedef struct packed {
        logic [1:0]  operation;
        logic [6:0]  address;
        logic [31:0] data;
    } in_item_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic [31:0] pc_value;
        logic [3:0]  control_state;
        logic [18:0] control_signals;
        logic [2:0]  error_code;
        logic        halted;
    } out_item_t;

    localparam logic [1:0] OP_LOAD_MEM = 2'd0;
    localparam logic [1:0] OP_CLOCK    = 2'd1;
    localparam logic [1:0] OP_READ_MEM = 2'd2;
    localparam logic [1:0] OP_READ_REG = 2'd3;

    localparam logic [5:0] OPC_RTYPE = 6'h00;
    localparam logic [5:0] OPC_J     = 6'h02;
    localparam logic [5:0] OPC_JAL   = 6'h03;
    localparam logic [5:0] OPC_BEQ   = 6'h04;
    localparam logic [5:0] OPC_BNE   = 6'h05;
    localparam logic [5:0] OPC_ADDI  = 6'h08;
    localparam logic [5:0] OPC_ANDI  = 6'h0C;
    localparam logic [5:0] OPC_JR    = 6'h14;
    localparam logic [5:0] OPC_JALR  = 6'h15;
    localparam logic [5:0] OPC_LW    = 6'h23;
    localparam logic [5:0] OPC_SW    = 6'h2B;

    localparam logic [5:0] FN_ADD = 6'h20;
    localparam logic [5:0] FN_SUB = 6'h22;
    localparam logic [5:0] FN_AND = 6'h24;
    localparam logic [5:0] FN_OR  = 6'h25;
    localparam logic [5:0] FN_SLT = 6'h2A;

    localparam logic [2:0] ERR_NONE   = 3'd0;
    localparam logic [2:0] ERR_INSTR  = 3'd1;
    localparam logic [2:0] ERR_MEM    = 3'd2;
    localparam logic [2:0] ERR_ALU    = 3'd3;
    localparam logic [2:0] ERR_REGWR  = 3'd4;

    // control word bit positions
    localparam int SIG_REGDST0  = 0;
    localparam int SIG_REGDST1  = 1;
    localparam int SIG_REGWRITE = 2;
    localparam int SIG_SRCA     = 3;
    localparam int SIG_SRCB0    = 4;
    localparam int SIG_SRCB1    = 5;
    localparam int SIG_ALUOP0   = 6;
    localparam int SIG_ALUOP1   = 7;
    localparam int SIG_PCSRC0   = 8;
    localparam int SIG_PCSRC1   = 9;
    localparam int SIG_PCCOND   = 10;
    localparam int SIG_PCWRITE  = 11;
    localparam int SIG_IORD     = 12;
    localparam int SIG_MEMREAD  = 13;
    localparam int SIG_MEMWRITE = 14;
    localparam int SIG_BNE      = 15;
    localparam int SIG_IRWRITE  = 16;
    localparam int SIG_MTR0     = 17;
    localparam int SIG_MTR1     = 18;

    localparam logic [18:0] CTL_WORD [16] = '{
        19'h12810, 19'h00030, 19'h00028, 19'h03000,
        19'h20004, 19'h05000, 19'h00088, 19'h00005,
        19'h00548, 19'h00A00, 19'h40A06, 19'h00B00,
        19'h40B04, 19'h00004, 19'h000E8, 19'h08548
    };

    function automatic logic opcode_valid(input logic [5:0] op);
        logic ok;
        case (op)
            OPC_RTYPE, OPC_J, OPC_JAL, OPC_BEQ, OPC_BNE, OPC_ADDI,
            OPC_ANDI, OPC_JR, OPC_JALR, OPC_LW, OPC_SW: ok = 1'b1;
            default: ok = 1'b0;
        endcase
        return ok;
    endfunction

    function automatic logic [3:0] next_state(input logic [3:0] s, input logic [5:0] op);
        logic e0, e1, e2, e3, e6, e14;
        logic lw, sw, addi, rt, j, jal, jr, jalr, andi, bne, beq;
        logic n0, n1, n2, n3;
        e0 = s == 4'd0; e1 = s == 4'd1; e2 = s == 4'd2; e3 = s == 4'd3;
        e6 = s == 4'd6; e14 = s == 4'd14;
        lw = op == OPC_LW; sw = op == OPC_SW; addi = op == OPC_ADDI;
        rt = op == OPC_RTYPE; j = op == OPC_J; jal = op == OPC_JAL;
        jr = op == OPC_JR; jalr = op == OPC_JALR; andi = op == OPC_ANDI;
        bne = op == OPC_BNE; beq = op == OPC_BEQ;
        n0 = e0 || (e1 && (j || jr || bne)) || e2 || e6 || e14;
        n1 = (e1 && (lw || sw || addi || rt || jal || jr || andi || bne)) || (e2 && lw) || e6;
        n2 = (e1 && (rt || jalr || andi || bne)) || (e2 && (sw || addi)) || e3 || e6 || e14;
        n3 = (e1 && (beq || j || jal || jr || jalr || andi || bne)) || (e2 && addi) || e14;
        return {n3, n2, n1, n0};
    endfunction

endpackage
`default_nettype wire

[src/multicycle_mips_core_unit.sv]
// Multicycle MIPS-style core: one input transfer = one host command or one core clock.
// Depends on mmc_pkg (types, opcodes, control table).
//
//  channel | signals                       | payload
//  in      | in_valid / in_ready           | mmc_pkg::in_item_t
//  out     | out_valid / out_ready         | mmc_pkg::out_item_t
//
// Every item completes in the cycle it is accepted; its result is in the output
// register on the next cycle. Throughput is one item per clock, set by the single
// pass through memory banks, ALU and register file. in_ready is low only while a
// result is held by a stalled consumer. Reset clears all architectural state.
`default_nettype none
module multicycle_mips_core_unit (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire mmc_pkg::in_item_t  in_item,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output mmc_pkg::out_item_t      out_item
);

    logic [7:0]  bank_reg [4][mmc_pkg::BANK_DEPTH];
    logic [31:0] rf_reg [32];
    logic [31:0] pc_reg, ir_reg, mdr_reg, a_reg, b_reg, alu_out_reg;
    logic [3:0]  state_reg;
    logic [2:0]  err_reg;
    logic        out_valid_reg;
    mmc_pkg::out_item_t out_item_reg;

    logic accept, clk_item;
    logic [18:0] sig;
    logic [5:0]  opc, fn;
    logic [4:0]  rs, rt, rd;
    logic [31:0] imm;

    // memory port
    logic [31:0] maddr;
    logic        maddr_ok;
    logic [mmc_pkg::MEM_AW-1:0] ma;
    logic [mmc_pkg::MEM_AW-1:0] wa [4];
    logic [31:0] mem_word;
    logic        mem_we;
    logic [31:0] mem_wdata;

    logic [31:0] srca, srcb, alu;
    logic        alu_err, take;
    logic [4:0]  wreg;
    logic [31:0] wdata, newpc, next_ir;
    logic        rf_we, reg_err;
    logic [2:0]  err_next, clk_err;
    logic [31:0] pc_next, ir_next, mdr_next, a_next, b_next;
    logic [31:0] rdata;

    assign accept   = in_valid && in_ready;
    assign in_ready = !out_valid_reg || out_ready;
    assign clk_item = in_item.operation == mmc_pkg::OP_CLOCK && err_reg == mmc_pkg::ERR_NONE;

    assign sig = clk_item ? mmc_pkg::CTL_WORD[state_reg] : '0;
    assign opc = ir_reg[31:26];
    assign fn  = ir_reg[5:0];
    assign rs  = ir_reg[25:21];
    assign rt  = ir_reg[20:16];
    assign rd  = ir_reg[15:11];
    assign imm = {{16{ir_reg[15]}}, ir_reg[15:0]};

    always_comb
    begin
        if (clk_item)
            maddr = sig[mmc_pkg::SIG_IORD] ? alu_out_reg : pc_reg;
        else
            maddr = {25'd0, in_item.address};
        maddr_ok = maddr <= 32'(mmc_pkg::RAM_BYTES - 4);
        ma = maddr[mmc_pkg::MEM_AW-1:0];
        for (int k = 0; k < 4; k++)
            wa[k] = ma + mmc_pkg::MEM_AW'(k);
    end

    // big-endian word over four byte banks; byte k of the word sits at ma+k
    always_comb
    begin
        mem_word = '0;
        for (int k = 0; k < 4; k++)
            mem_word[31-8*k -: 8] = bank_reg[wa[k][1:0]][wa[k][mmc_pkg::MEM_AW-1:2]];
        if (!maddr_ok)
            mem_word = '0;
    end

    always_comb
    begin
        if (clk_item)
        begin
            mem_we    = sig[mmc_pkg::SIG_MEMWRITE] && maddr_ok;
            mem_wdata = b_reg;
        end
        else
        begin
            mem_we    = in_item.operation == mmc_pkg::OP_LOAD_MEM && maddr_ok;
            mem_wdata = in_item.data;
        end
    end

    always_comb
    begin
        srca = sig[mmc_pkg::SIG_SRCA] ? a_reg : pc_reg;
        case ({sig[mmc_pkg::SIG_SRCB1], sig[mmc_pkg::SIG_SRCB0]})
            2'd0:    srcb = b_reg;
            2'd1:    srcb = 32'd4;
            2'd2:    srcb = imm;
            default: srcb = {imm[29:0], 2'b00};
        endcase
        alu_err = 1'b0;
        case ({sig[mmc_pkg::SIG_ALUOP1], sig[mmc_pkg::SIG_ALUOP0]})
            2'd0: alu = srca + srcb;
            2'd1: alu = srca - srcb;
            2'd3: alu = srca & srcb;
            default:
            begin
                unique case (fn)
                    mmc_pkg::FN_ADD: alu = srca + srcb;
                    mmc_pkg::FN_SUB: alu = srca - srcb;
                    mmc_pkg::FN_AND: alu = srca & srcb;
                    mmc_pkg::FN_OR:  alu = srca | srcb;
                    mmc_pkg::FN_SLT: alu = {31'd0, $signed(srca) < $signed(srcb)};
                    default:
                    begin
                        alu     = '0;
                        alu_err = 1'b1;
                    end
                endcase
            end
        endcase
    end

    always_comb
    begin
        wreg = sig[mmc_pkg::SIG_REGDST1] ? 5'd31 : (sig[mmc_pkg::SIG_REGDST0] ? rd : rt);
        wdata = sig[mmc_pkg::SIG_MTR1] ? pc_reg :
                (sig[mmc_pkg::SIG_MTR0] ? mdr_reg : alu_out_reg);
        reg_err = sig[mmc_pkg::SIG_REGWRITE] &&
                  (wreg == 5'd0 || wreg == 5'd1 || wreg == 5'd26 || wreg == 5'd27);
        rf_we = clk_item && sig[mmc_pkg::SIG_REGWRITE] && !reg_err;

        case ({sig[mmc_pkg::SIG_PCSRC1], sig[mmc_pkg::SIG_PCSRC0]})
            2'd0:    newpc = alu;
            2'd1:    newpc = alu_out_reg;
            2'd2:    newpc = {pc_reg[31:28], ir_reg[25:0], 2'b00};
            default: newpc = a_reg;
        endcase
        take = (sig[mmc_pkg::SIG_PCCOND] &&
                (sig[mmc_pkg::SIG_BNE] ? (alu != '0) : (alu == '0))) ||
               sig[mmc_pkg::SIG_PCWRITE];
        next_ir = mem_word;
    end

    always_comb
    begin
        pc_next  = pc_reg;
        ir_next  = ir_reg;
        mdr_next = mdr_reg;
        // operand reads see this cycle's register write
        a_next   = (rf_we && wreg == rs) ? wdata : rf_reg[rs];
        b_next   = (rf_we && wreg == rt) ? wdata : rf_reg[rt];
        if (take)
            pc_next = newpc;
        if (sig[mmc_pkg::SIG_IRWRITE])
            ir_next = next_ir;
        if (sig[mmc_pkg::SIG_MEMREAD])
            mdr_next = mem_word;

        clk_err = mmc_pkg::ERR_NONE;
        if ((sig[mmc_pkg::SIG_MEMREAD] || sig[mmc_pkg::SIG_MEMWRITE]) && !maddr_ok)
            clk_err = mmc_pkg::ERR_MEM;
        else if (alu_err)
            clk_err = mmc_pkg::ERR_ALU;
        else if (reg_err)
            clk_err = mmc_pkg::ERR_REGWR;
        if (!mmc_pkg::opcode_valid(ir_next[31:26]))
            clk_err = mmc_pkg::ERR_INSTR;

        err_next = err_reg;
        if (clk_item)
            err_next = clk_err;
        else if (in_item.operation == mmc_pkg::OP_LOAD_MEM && !maddr_ok &&
                 err_reg == mmc_pkg::ERR_NONE)
            err_next = mmc_pkg::ERR_MEM;

        rdata = '0;
        if (in_item.operation == mmc_pkg::OP_READ_MEM)
            rdata = mem_word;
        else if (in_item.operation == mmc_pkg::OP_READ_REG && !in_item.address[6] &&
                 !in_item.address[5])
            rdata = rf_reg[in_item.address[4:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 32; i++)
                rf_reg[i] <= '0;
            for (int b = 0; b < 4; b++)
                for (int i = 0; i < mmc_pkg::BANK_DEPTH; i++)
                    bank_reg[b][i] <= '0;
            pc_reg        <= '0;
            ir_reg        <= '0;
            mdr_reg       <= '0;
            a_reg         <= '0;
            b_reg         <= '0;
            alu_out_reg   <= '0;
            state_reg     <= '0;
            err_reg       <= mmc_pkg::ERR_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                if (mem_we)
                begin
                    for (int k = 0; k < 4; k++)
                    begin
                        bank_reg[wa[k][1:0]][wa[k][mmc_pkg::MEM_AW-1:2]]
                            <= mem_wdata[31-8*k -: 8];
                    end
                end
                if (rf_we)
                    rf_reg[wreg] <= wdata;
                if (clk_item)
                begin
                    pc_reg      <= pc_next;
                    ir_reg      <= ir_next;
                    mdr_reg     <= mdr_next;
                    a_reg       <= a_next;
                    b_reg       <= b_next;
                    alu_out_reg <= alu;
                    state_reg   <= mmc_pkg::next_state(state_reg, opc);
                end
                err_reg <= err_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_item_reg.read_data       <= rdata;
            out_item_reg.pc_value        <= clk_item ? pc_next : pc_reg;
            out_item_reg.control_state   <= clk_item ? mmc_pkg::next_state(state_reg, opc)
                                                     : state_reg;
            out_item_reg.control_signals <= sig;
            out_item_reg.error_code      <= err_next;
            out_item_reg.halted          <= err_next != mmc_pkg::ERR_NONE;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule
`default_nettype wire

[src/mmc_checker.sv]
// Port-level checker for multicycle_mips_core_unit, bound into every instance of that module.
// Depends on mmc_pkg.
`default_nettype none
module mmc_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_ready,
    input wire mmc_pkg::in_item_t  in_item,
    input wire logic               out_valid,
    input wire logic               out_ready,
    input wire mmc_pkg::out_item_t out_item
);

    a_halt_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_item.halted == (out_item.error_code != mmc_pkg::ERR_NONE)))
        else $error("halted disagrees with error_code");

    a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_item.error_code <= mmc_pkg::ERR_REGWR))
        else $error("error_code out of range");

    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_item))
        else $error("stalled result changed");

    a_fetch_only_clock: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_item.operation != mmc_pkg::OP_CLOCK
        |=> out_item.control_signals == '0)
        else $error("control word issued for a host command");

endmodule

bind multicycle_mips_core_unit mmc_checker u_mmc_checker (.*);
`default_nettype wire

[tb/mmc_checker.sv]
// Checker for the multicycle MIPS-style core: watches both channels, predicts each result
// from its own copy of the architectural state, and compares. Depends on mmc_pkg.
`default_nettype none
module mmc_result_checker (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic               in_ready,
    input  wire mmc_pkg::in_item_t  in_item,
    input  wire logic               out_valid,
    input  wire logic               out_ready,
    input  wire mmc_pkg::out_item_t out_item,
    output int                      fail_count,
    output int                      pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import mmc_pkg::*;

    logic [31:0] gpr [32];
    logic [7:0]  ram [RAM_BYTES];
    logic [31:0] pc, ir, mdr, reg_a, reg_b, alu_out;
    logic [3:0]  fsm;
    logic [2:0]  err_status;
    out_item_t   expected_q [$];

    function automatic logic word_ok(logic [31:0] a);
        return a <= 32'(RAM_BYTES - 4);
    endfunction

    function automatic logic [31:0] ram_word(logic [31:0] a);
        return {ram[a], ram[a + 1], ram[a + 2], ram[a + 3]};
    endfunction

    task automatic ram_store(logic [31:0] a, logic [31:0] v);
        ram[a] = v[31:24];
        ram[a + 1] = v[23:16];
        ram[a + 2] = v[15:8];
        ram[a + 3] = v[7:0];
    endtask

    function automatic logic [3:0] fsm_next(logic [3:0] s, logic [5:0] op);
        logic e1, e2;
        logic n0, n1, n2, n3;
        e1 = s == 4'd1;
        e2 = s == 4'd2;
        n0 = s == 4'd0 || (e1 && (op == OPC_J || op == OPC_JR || op == OPC_BNE)) || e2
            || s == 4'd6 || s == 4'd14;
        n1 = (e1 && (op == OPC_LW || op == OPC_SW || op == OPC_ADDI || op == OPC_RTYPE
            || op == OPC_JAL || op == OPC_JR || op == OPC_ANDI || op == OPC_BNE))
            || (e2 && op == OPC_LW) || s == 4'd6;
        n2 = (e1 && (op == OPC_RTYPE || op == OPC_JALR || op == OPC_ANDI || op == OPC_BNE))
            || (e2 && (op == OPC_SW || op == OPC_ADDI)) || s == 4'd3 || s == 4'd6
            || s == 4'd14;
        n3 = (e1 && (op == OPC_BEQ || op == OPC_J || op == OPC_JAL || op == OPC_JR
            || op == OPC_JALR || op == OPC_ANDI || op == OPC_BNE))
            || (e2 && op == OPC_ADDI) || s == 4'd14;
        return {n3, n2, n1, n0};
    endfunction

    function automatic logic known_opcode(logic [5:0] op);
        case (op)
            OPC_RTYPE, OPC_J, OPC_JAL, OPC_BEQ, OPC_BNE, OPC_ADDI,
            OPC_ANDI, OPC_JR, OPC_JALR, OPC_LW, OPC_SW: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    // one core clock; returns the control word used
    task automatic core_cycle(output logic [18:0] ctl);
        logic [18:0] s;
        logic [5:0]  op, fn;
        logic [4:0]  rs, rt, rd, wreg;
        logic [31:0] imm, srca, srcb, alu, maddr, npc, nir, nmdr, w, wdata;
        logic [2:0]  err;
        logic [1:0]  sel;
        logic        take;
        s = CTL_WORD[fsm];
        op = ir[31:26];
        fn = ir[5:0];
        rs = ir[25:21];
        rt = ir[20:16];
        rd = ir[15:11];
        imm = {{16{ir[15]}}, ir[15:0]};
        err = ERR_NONE;
        nir = ir;
        nmdr = mdr;
        maddr = s[SIG_IORD] ? alu_out : pc;
        if (s[SIG_MEMREAD])
        begin
            w = '0;
            if (word_ok(maddr)) w = ram_word(maddr);
            else err = ERR_MEM;
            nmdr = w;
            nir = w;
        end
        if (s[SIG_MEMWRITE])
        begin
            if (word_ok(maddr)) ram_store(maddr, reg_b);
            else if (err == ERR_NONE) err = ERR_MEM;
        end
        srca = s[SIG_SRCA] ? reg_a : pc;
        sel = {s[SIG_SRCB1], s[SIG_SRCB0]};
        srcb = sel == 2'd0 ? reg_b : sel == 2'd1 ? 32'd4 : sel == 2'd2 ? imm : imm << 2;
        sel = {s[SIG_ALUOP1], s[SIG_ALUOP0]};
        if (sel == 2'd0) alu = srca + srcb;
        else if (sel == 2'd1) alu = srca - srcb;
        else if (sel == 2'd3) alu = srca & srcb;
        else
        begin
            case (fn)
                FN_ADD: alu = srca + srcb;
                FN_SUB: alu = srca - srcb;
                FN_AND: alu = srca & srcb;
                FN_OR:  alu = srca | srcb;
                FN_SLT: alu = {31'd0, $signed(srca) < $signed(srcb)};
                default:
                begin
                    alu = '0;
                    if (err == ERR_NONE) err = ERR_ALU;
                end
            endcase
        end
        if (s[SIG_REGWRITE])
        begin
            wreg = s[SIG_REGDST1] ? 5'd31 : s[SIG_REGDST0] ? rd : rt;
            wdata = s[SIG_MTR1] ? pc : s[SIG_MTR0] ? mdr : alu_out;
            if (wreg < 5'd2 || wreg == 5'd26 || wreg == 5'd27)
            begin
                if (err == ERR_NONE) err = ERR_REGWR;
            end
            else gpr[wreg] = wdata;
        end
        sel = {s[SIG_PCSRC1], s[SIG_PCSRC0]};
        npc = sel == 2'd0 ? alu : sel == 2'd1 ? alu_out
            : sel == 2'd2 ? {pc[31:28], ir[25:0], 2'b00} : reg_a;
        take = (s[SIG_PCCOND] && (s[SIG_BNE] ? alu != '0 : alu == '0)) || s[SIG_PCWRITE];
        reg_a = gpr[rs];
        reg_b = gpr[rt];
        if (take) pc = npc;
        if (s[SIG_IRWRITE]) ir = nir;
        mdr = nmdr;
        alu_out = alu;
        fsm = fsm_next(fsm, op);
        if (!known_opcode(ir[31:26])) err = ERR_INSTR;
        err_status = err;
        ctl = s;
    endtask

    task automatic predict_item(in_item_t it);
        out_item_t r;
        logic [18:0] ctl;
        r = '0;
        ctl = '0;
        case (it.operation)
            OP_LOAD_MEM:
                if (word_ok(32'(it.address))) ram_store(32'(it.address), it.data);
                else if (err_status == ERR_NONE) err_status = ERR_MEM;
            OP_CLOCK:
                if (err_status == ERR_NONE) core_cycle(ctl);
            OP_READ_MEM:
                if (word_ok(32'(it.address))) r.read_data = ram_word(32'(it.address));
            default:
                if (it.address < 7'd32) r.read_data = gpr[it.address[4:0]];
        endcase
        r.pc_value = pc;
        r.control_state = fsm;
        r.control_signals = ctl;
        r.error_code = err_status;
        r.halted = err_status != ERR_NONE;
        expected_q.push_back(r);
    endtask

    assign pending = expected_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t e;
        if (!rst_n)
        begin
            foreach (gpr[i]) gpr[i] = '0;
            foreach (ram[i]) ram[i] = '0;
            {pc, ir, mdr, reg_a, reg_b, alu_out} = '0;
            fsm = '0;
            err_status = ERR_NONE;
            expected_q.delete();
            fail_count = 0;
        end
        else
        begin
            // results first: an item accepted now cannot show up on this edge
            if (out_valid && out_ready)
            begin
                if (expected_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10) $display("unexpected result %h", out_item);
                end
                else
                begin
                    e = expected_q.pop_front();
                    if (e !== out_item)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"mismatch: exp rd=%h pc=%h st=%0d ctl=%h err=%0d h=%b",
                                      " got rd=%h pc=%h st=%0d ctl=%h err=%0d h=%b"},
                                     e.read_data, e.pc_value, e.control_state,
                                     e.control_signals, e.error_code, e.halted,
                                     out_item.read_data, out_item.pc_value,
                                     out_item.control_state, out_item.control_signals,
                                     out_item.error_code, out_item.halted);
                    end
                end
            end
            if (in_valid && in_ready) predict_item(in_item);
        end
    end
endmodule
`default_nettype wire

[tb/tb_top.sv]
// Top of the testbench for multicycle_mips_core_unit: clock, reset, stimulus programs,
// receiver stalls and verdict. Depends on mmc_pkg and mmc_result_checker.
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import mmc_pkg::*;

    localparam int IDLE_LIMIT = 5000;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    in_item_t  in_item = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_item_t out_item;
    int        fail_count;
    int        pending;
    logic      stimulus_done = 1'b0;
    logic      hold_off = 1'b0;
    int        idle_cycles = 0;

    multicycle_mips_core_unit dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
        .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
    );

    mmc_result_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
        .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
        .fail_count(fail_count), .pending(pending)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // valid drops only when a gap follows, so back-to-back transfers keep it high
    task automatic send(logic [1:0] op, logic [6:0] addr, logic [31:0] data);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= '{operation: op, address: addr, data: data};
        do @(posedge clk); while (!in_ready);
    endtask

    function automatic logic [31:0] r_word(logic [4:0] rs, logic [4:0] rt, logic [4:0] rd,
                                           logic [5:0] fn);
        return {OPC_RTYPE, rs, rt, rd, 5'd0, fn};
    endfunction

    function automatic logic [31:0] i_word(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                           logic [15:0] imm);
        return {op, rs, rt, imm};
    endfunction

    function automatic logic [4:0] ok_reg();
        logic [4:0] r;
        do r = 5'($urandom_range(2, 31)); while (r == 5'd26 || r == 5'd27);
        return r;
    endfunction

    function automatic logic [4:0] any_reg();
        return 5'($urandom_range(0, 31));
    endfunction

    // a mostly well-formed random instruction; sometimes a broken one
    function automatic logic [31:0] rand_instr(int words);
        logic [5:0] fns [5];
        logic [5:0] ops [10];
        int p;
        fns = '{FN_ADD, FN_SUB, FN_AND, FN_OR, FN_SLT};
        ops = '{OPC_J, OPC_JAL, OPC_BEQ, OPC_BNE, OPC_ADDI, OPC_ANDI, OPC_JR,
                OPC_JALR, OPC_LW, OPC_SW};
        p = $urandom_range(0, 99);
        if (p < 3) return $urandom;
        if (p < 30)
            return r_word(any_reg(), any_reg(), ok_reg(),
                          p < 5 ? 6'($urandom) : fns[$urandom_range(0, 4)]);
        case (ops[$urandom_range(0, 9)])
            OPC_J:    return {OPC_J, 26'($urandom_range(0, words - 1))};
            OPC_JAL:  return {OPC_JAL, 26'($urandom_range(0, words - 1))};
            OPC_BEQ:  return i_word(OPC_BEQ, any_reg(), any_reg(),
                                    16'($signed($urandom_range(0, 6)) - 3));
            OPC_BNE:  return i_word(OPC_BNE, any_reg(), any_reg(),
                                    16'($signed($urandom_range(0, 6)) - 3));
            OPC_ADDI: return i_word(OPC_ADDI, any_reg(), ok_reg(), 16'($urandom));
            OPC_ANDI: return i_word(OPC_ANDI, any_reg(), ok_reg(), 16'($urandom));
            OPC_JR:   return i_word(OPC_JR, 5'd0, ok_reg(), 16'd0);
            OPC_JALR: return i_word(OPC_JALR, 5'd0, ok_reg(), 16'd0);
            OPC_LW:   return i_word(OPC_LW, 5'd0, ok_reg(), 16'($urandom_range(0, 31) * 4));
            default:  return i_word(OPC_SW, 5'd0, ok_reg(), 16'($urandom_range(0, 31) * 4));
        endcase
    endfunction

    initial
    begin
        int sent, words, n;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes of loads/reads and a short program of ADDI, ANDI, R-type, SW, LW, BEQ, BNE and JAL
        send(OP_LOAD_MEM, 7'd124, 32'hFFFF_FFFF);
        send(OP_READ_MEM, 7'd124, 32'h0);
        send(OP_READ_MEM, 7'd125, 32'hFFFF_FFFF);
        send(OP_READ_REG, 7'd127, 32'h0);
        send(OP_READ_REG, 7'd31, 32'h0);
        send(OP_LOAD_MEM, 7'd0, i_word(OPC_ADDI, 5'd0, 5'd2, 16'h8000));
        send(OP_LOAD_MEM, 7'd4, i_word(OPC_ANDI, 5'd2, 5'd3, 16'hFFFF));
        send(OP_LOAD_MEM, 7'd8, r_word(5'd2, 5'd3, 5'd4, FN_SLT));
        send(OP_LOAD_MEM, 7'd12, r_word(5'd2, 5'd3, 5'd5, FN_SUB));
        send(OP_LOAD_MEM, 7'd16, r_word(5'd4, 5'd5, 5'd6, FN_OR));
        send(OP_LOAD_MEM, 7'd20, i_word(OPC_SW, 5'd0, 5'd2, 16'd96));
        send(OP_LOAD_MEM, 7'd24, i_word(OPC_LW, 5'd0, 5'd7, 16'd96));
        send(OP_LOAD_MEM, 7'd28, i_word(OPC_BEQ, 5'd2, 5'd7, 16'd1));
        send(OP_LOAD_MEM, 7'd36, i_word(OPC_BNE, 5'd2, 5'd0, 16'd0));
        send(OP_LOAD_MEM, 7'd40, {OPC_JAL, 26'd12});
        send(OP_LOAD_MEM, 7'd48, r_word(5'd2, 5'd3, 5'd8, 6'h3F));
        repeat (90) send(OP_CLOCK, 7'($urandom), $urandom);
        send(OP_READ_REG, 7'd4, 32'h0);
        send(OP_LOAD_MEM, 7'd126, 32'h1234_5678);
        send(OP_CLOCK, 7'd0, 32'h0);

        // random: the core halts on errors, so the stream is made of programs that
        // are only ever run until the error status sticks; this keeps state deep
        sent = 0;
        while (sent < 830)
        begin
            words = $urandom_range(4, 24);
            for (int i = 0; i < words; i++)
            begin
                send(OP_LOAD_MEM, 7'(i * 4), rand_instr(words));
                sent++;
            end
            n = $urandom_range(10, 60);
            for (int i = 0; i < n; i++)
            begin
                case ($urandom_range(0, 19))
                    0: send(OP_READ_MEM, 7'($urandom), $urandom);
                    1: send(OP_READ_REG, 7'($urandom), $urandom);
                    2: send(OP_LOAD_MEM, 7'(4 * $urandom_range(words, 31)), $urandom);
                    default: send(OP_CLOCK, 7'($urandom), $urandom);
                endcase
                sent++;
            end
        end
        // bad load address, then halted clocks
        send(OP_LOAD_MEM, 7'd125, 32'hA5A5_A5A5);
        repeat (3) send(OP_CLOCK, 7'd0, 32'h0);
        in_valid <= 1'b0;
        stimulus_done <= 1'b1;
    end

    // receiver: random stalls plus one long hold-off early in the run
    initial
    begin
        repeat (60) @(posedge clk);
        hold_off <= 1'b1;
        repeat (200) @(posedge clk);
        hold_off <= 1'b0;
    end

    always @(posedge clk)
    begin
        int p;
        p = $urandom_range(0, 99);
        if (hold_off) out_ready <= 1'b0;
        else if (p < 60) out_ready <= 1'b1;
        else if (p < 97) out_ready <= 1'b0;
        else out_ready <= 1'b0;
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        wait (stimulus_done);
        while (pending != 0 && idle_cycles < IDLE_LIMIT) @(posedge clk);
        repeat (10) @(posedge clk);
        if (fail_count == 0 && pending == 0) $display("PASSED: all results match");
        else $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        wait (idle_cycles >= IDLE_LIMIT);
        $display("FAILED: results differ");
        $finish;
    end
endmodule
`default_nettype wire

[multicycle_mips_core_unit.f]
src/mmc_pkg.sv
src/multicycle_mips_core_unit.sv
src/mmc_checker.sv
tb/mmc_checker.sv
tb/tb_top.sv
